// ===== src/afr_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte update for the
// addressed frame receiver. No dependencies.
`default_nettype none

package afr_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam int unsigned BITS_PER_BYTE = 8;

	// header byte positions
	localparam logic [2:0] HDR_ADDR_HI = 3'd0;
	localparam logic [2:0] HDR_ADDR_LO = 3'd1;
	localparam logic [2:0] HDR_CRC_HI  = 3'd2;
	localparam logic [2:0] HDR_CRC_LO  = 3'd3;
	localparam logic [2:0] HDR_LENGTH  = 3'd4;
	localparam logic [2:0] HDR_SUM     = 3'd5;

	// register word indexes
	localparam logic REG_LOCAL_ADDRESS = 1'b0;

	typedef enum logic {
		PHASE_HEADER  = 1'b0,
		PHASE_PAYLOAD = 1'b1
	} afr_phase_t;

	typedef enum logic [1:0] {
		STATUS_CRC_OK  = 2'd0,
		STATUS_CRC_BAD = 2'd1,
		STATUS_HDR_BAD = 2'd2
	} afr_status_t;

	typedef struct packed {
		afr_status_t status;
		logic [7:0]  length;
		logic [15:0] crc;
	} afr_result_t;

	// reflected CRC-16 update, one byte
	function automatic logic [15:0] afr_crc_byte(input logic [15:0] crc_in,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < BITS_PER_BYTE; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== src/addressed_frame_receiver.sv =====
// Addressed frame receiver: header parser, payload CRC-16/MODBUS check,
// result register with skid stage and APB register port. Uses afr_pkg.
`default_nettype none

// The receiver takes one byte per cycle on the rx channel and reports one
// transaction on the frame channel per finished frame. A frame is a six-byte
// header (address high, address low, CRC high, CRC low, payload length,
// 8-bit sum of the first five bytes) followed by the payload. Bytes whose
// address does not match local_address are dropped without a report and the
// parser restarts at header byte 0. A bad header sum reports status 2 with a
// zero CRC; otherwise the payload is run through CRC-16/MODBUS and the frame
// reports status 0 (match) or 1 (mismatch) on its last payload byte, or on
// the sum byte when the length is zero. Each byte is handled on acceptance:
// the parser state and a byte-wide CRC update sit between the parser
// registers and the result register, so a byte can be accepted every cycle.
// The result register is backed by a one-entry skid buffer; rx_ready drops
// only while both hold undelivered reports. A report appears on the frame
// channel the cycle after its last byte is accepted when the result register
// is empty or is being taken in that cycle; otherwise it waits in the skid
// entry until the report ahead of it is taken. local_address sits at
// APB byte address 0 and should be written only while the receiver is idle.
module addressed_frame_receiver
	import afr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	// received bytes
	input  wire logic        rx_valid,
	output logic             rx_ready,
	input  wire logic [7:0]  rx_byte,

	// frame reports
	output logic             frame_valid,
	input  wire logic        frame_ready,
	output logic [1:0]       frame_status,
	output logic [7:0]       frame_length,
	output logic [15:0]      computed_crc,

	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// ---------------------------------------------------------------
	// register port
	// ---------------------------------------------------------------
	logic [15:0] local_address_q;
	logic        reg_sel;
	logic        reg_wr;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_LOCAL_ADDRESS);
	assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? {16'h0000, local_address_q} : 32'h0000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q <= '0;
		end else if (reg_wr) begin
			local_address_q <= pwdata[15:0];
		end
	end

	// ---------------------------------------------------------------
	// parser state
	// ---------------------------------------------------------------
	afr_phase_t  phase_q, phase_d;
	logic [2:0]  hpos_q, hpos_d;
	logic [7:0]  hsum_q, hsum_d;
	logic [15:0] exp_crc_q, exp_crc_d;
	logic [7:0]  plen_q, plen_d;
	logic [7:0]  remain_q, remain_d;
	logic [15:0] crc_q, crc_d;

	logic        rx_fire;
	logic        res_v;
	afr_result_t res;
	logic        restart;
	logic        advance;
	logic [15:0] crc_upd;
	logic [7:0]  remain_dec;

	assign rx_fire = rx_valid && rx_ready;

	always_comb begin
		phase_d    = phase_q;
		hpos_d     = hpos_q;
		hsum_d     = hsum_q;
		exp_crc_d  = exp_crc_q;
		plen_d     = plen_q;
		remain_d   = remain_q;
		crc_d      = crc_q;
		res_v      = 1'b0;
		res.status = STATUS_CRC_OK;
		res.length = plen_q;
		res.crc    = '0;
		restart    = 1'b0;
		advance    = 1'b0;
		crc_upd    = afr_crc_byte(crc_q, rx_byte);
		remain_dec = remain_q - 8'd1;

		if (phase_q == PHASE_PAYLOAD) begin
			crc_d    = crc_upd;
			remain_d = remain_dec;
			if (remain_dec == 8'd0) begin
				res_v      = 1'b1;
				res.status = (crc_upd == exp_crc_q) ? STATUS_CRC_OK : STATUS_CRC_BAD;
				res.crc    = crc_upd;
				restart    = 1'b1;
			end
		end else begin
			unique case (hpos_q)
				HDR_ADDR_HI: begin
					if (rx_byte != local_address_q[15:8]) begin
						restart = 1'b1;
					end else begin
						advance = 1'b1;
					end
				end
				HDR_ADDR_LO: begin
					if (rx_byte != local_address_q[7:0]) begin
						restart = 1'b1;
					end else begin
						advance = 1'b1;
					end
				end
				HDR_CRC_HI: begin
					exp_crc_d = {rx_byte, exp_crc_q[7:0]};
					advance   = 1'b1;
				end
				HDR_CRC_LO: begin
					exp_crc_d = {exp_crc_q[15:8], rx_byte};
					advance   = 1'b1;
				end
				HDR_LENGTH: begin
					plen_d  = rx_byte;
					advance = 1'b1;
				end
				default: begin
					// header sum byte
					if (rx_byte != hsum_q) begin
						res_v      = 1'b1;
						res.status = STATUS_HDR_BAD;
						restart    = 1'b1;
					end else if (plen_q == 8'd0) begin
						res_v      = 1'b1;
						res.status = (exp_crc_q == CRC_INIT) ? STATUS_CRC_OK
							: STATUS_CRC_BAD;
						res.crc    = CRC_INIT;
						restart    = 1'b1;
					end else begin
						phase_d  = PHASE_PAYLOAD;
						hpos_d   = HDR_ADDR_HI;
						remain_d = plen_q;
						crc_d    = CRC_INIT;
					end
				end
			endcase
		end

		if (advance) begin
			hsum_d = hsum_q + rx_byte;
			hpos_d = hpos_q + 3'd1;
		end

		if (restart) begin
			phase_d = PHASE_HEADER;
			hpos_d  = HDR_ADDR_HI;
			hsum_d  = '0;
			crc_d   = CRC_INIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PHASE_HEADER;
			hpos_q    <= HDR_ADDR_HI;
			hsum_q    <= '0;
			exp_crc_q <= '0;
			plen_q    <= '0;
			remain_q  <= '0;
			crc_q     <= CRC_INIT;
		end else if (rx_fire) begin
			phase_q   <= phase_d;
			hpos_q    <= hpos_d;
			hsum_q    <= hsum_d;
			exp_crc_q <= exp_crc_d;
			plen_q    <= plen_d;
			remain_q  <= remain_d;
			crc_q     <= crc_d;
		end
	end

	// ---------------------------------------------------------------
	// result register + skid entry
	// ---------------------------------------------------------------
	logic        out_v_q;
	logic        skid_v_q;
	afr_result_t out_q;
	afr_result_t skid_q;
	logic        out_free;
	logic        res_fire;

	assign rx_ready = !skid_v_q;
	assign out_free = !out_v_q || frame_ready;
	assign res_fire = rx_fire && res_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= res_fire;
			end
		end else if (res_fire) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (res_fire) begin
				out_q <= res;
			end
		end else if (res_fire) begin
			skid_q <= res;
		end
	end

	assign frame_valid  = out_v_q;
	assign frame_status = out_q.status;
	assign frame_length = out_q.length;
	assign computed_crc = out_q.crc;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held while result register empty");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PHASE_PAYLOAD) |-> (remain_q != 8'd0))
		else $error("payload phase with no bytes remaining");

	a_hpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		hpos_q <= HDR_SUM)
		else $error("header position past the sum byte");

	a_hdr_err_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && (frame_status == STATUS_HDR_BAD)) |-> (computed_crc == 16'h0000))
		else $error("header error report with nonzero CRC");

	a_payload_crc_init: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(phase_q == PHASE_PAYLOAD) |-> (crc_q == CRC_INIT))
		else $error("payload phase entered without CRC preset");

endmodule

`default_nettype wire
